### rtl/core/rv32x_pkg.sv
// ----------------------------------------------------------------------------
// rv32x_pkg
// Shared constants, codes and types of the RV32 subset instruction executor.
// ----------------------------------------------------------------------------
package rv32x_pkg;

  // Data memory size in bytes and its address width
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

  // Major opcodes
  localparam logic [6:0] OP_R   = 7'h33;
  localparam logic [6:0] OP_I   = 7'h13;
  localparam logic [6:0] OP_BR  = 7'h63;
  localparam logic [6:0] OP_JAL = 7'h6F;
  localparam logic [6:0] OP_ST  = 7'h23;
  localparam logic [6:0] OP_LD  = 7'h03;
  localparam logic [6:0] OP_LUI = 7'h37;
  localparam logic [6:0] OP_SYS = 7'h73;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ILLEGAL  = 3'd1;
  localparam logic [2:0] ST_BADREAD  = 3'd2;
  localparam logic [2:0] ST_BADWRITE = 3'd3;
  localparam logic [2:0] ST_ECALL    = 3'd4;
  localparam logic [2:0] ST_EXIT     = 3'd5;
  localparam logic [2:0] ST_HALTED   = 3'd6;

  // Class assigned to each request by the front end
  typedef enum logic [2:0] {
    CL_HOST,
    CL_ALU,
    CL_MUL,
    CL_DIV,
    CL_LOAD,
    CL_STORE,
    CL_SYS,
    CL_ILLEGAL
  } op_class_t;

  // Queue entry from front to back
  typedef struct packed {
    op_class_t   cls;
    logic [31:0] instr;
    logic [15:0] host_address;
    logic [31:0] host_word;
  } item_t;

  // One result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] ecall_number;
    logic [31:0] ecall_argument;
  } result_t;

  // Divider control and status
  typedef struct packed {
    logic        start;
    logic        is_rem;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } div_rsp_t;

endpackage

### rtl/core/rv32x_if.sv
// ----------------------------------------------------------------------------
// rv32x_if
// Valid/ready channels of the executor: requests, results and configuration.
// ----------------------------------------------------------------------------
interface rv32x_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] instr_word;
  logic [15:0] host_address;
  logic [31:0] host_word;

  modport source (output valid, kind, instr_word, host_address, host_word, input ready);
  modport sink   (input valid, kind, instr_word, host_address, host_word, output ready);
endinterface

interface rv32x_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] next_pc;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic [31:0] ecall_number;
  logic [31:0] ecall_argument;

  modport source (output valid, status, next_pc, dest_index, dest_value, ecall_number,
                  ecall_argument, input ready);
  modport sink   (input valid, status, next_pc, dest_index, dest_value, ecall_number,
                  ecall_argument, output ready);
endinterface

interface rv32x_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_pc;

  modport source (output valid, start_pc, input ready);
  modport sink   (input valid, start_pc, output ready);
endinterface

### rtl/core/rv32_subset_instruction_executor.sv
// ----------------------------------------------------------------------------
// rv32_subset_instruction_executor
// RV32 subset executor: a classifying front end, a two-entry queue and an
// execution back end with register file, PC, data memory, multiplier and
// iterative divider.
// ----------------------------------------------------------------------------
// Each request gives one result. The back end takes a request from the
// queue (register read) in S_IDLE, executes it in S_EXEC and commits it
// into the output register in S_WB. MUL/MULH add S_MUL, DIV/REM S_DIVW (32
// quotient bits, one per cycle), loads S_MRA and S_MRB per byte and stores
// and host writes S_MWR per byte, all set by the single byte-wide data
// memory port; ALU, branch, jump, ecall and faults add none. The front end
// keeps queueing while it has room and the back end works, and a result
// waiting in the output register stalls only the commit step. Data memory
// has no reset; reading a byte never written returns an undefined value.
module rv32_subset_instruction_executor (
  input  logic         clk,
  input  logic         rst_n,
  rv32x_in_if.sink     in_ch,
  rv32x_out_if.source  out_ch,
  rv32x_cfg_if.sink    cfg_ch
);
  import rv32x_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  rv32x_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  rv32x_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch)
  );

endmodule

### rtl/core/rv32x_front.sv
// ----------------------------------------------------------------------------
// rv32x_front
// Accepts requests, classifies and checks the encoding, and queues them.
// ----------------------------------------------------------------------------
module rv32x_front (
  input  logic              clk,
  input  logic              rst_n,
  rv32x_in_if.sink          in_ch,
  output rv32x_pkg::item_t  q_item,
  output logic              q_valid,
  input  logic              q_ready
);
  import rv32x_pkg::*;

  item_t       ent_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  q_cnt_r;
  logic        push;
  logic        pop;
  item_t       dec_item;

  // Classify one instruction word
  function automatic op_class_t classify(logic [31:0] w);
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    op_class_t  c;
    op = w[6:0];
    f3 = w[14:12];
    f7 = w[31:25];
    c  = CL_ILLEGAL;
    case (op)
      OP_R: begin
        if (f7 == 7'h00) begin
          if (f3 != 3'd3) c = CL_ALU;
        end else if (f7 == 7'h01) begin
          if (f3 inside {3'd0, 3'd1}) c = CL_MUL;
          else if (f3 inside {3'd4, 3'd6}) c = CL_DIV;
        end else if (f7 == 7'h20) begin
          if (f3 inside {3'd0, 3'd5}) c = CL_ALU;
        end
      end
      OP_I: begin
        case (f3)
          3'd1:    if (f7 == 7'h00) c = CL_ALU;
          3'd3:    c = CL_ILLEGAL;
          3'd5:    if (f7 inside {7'h00, 7'h20}) c = CL_ALU;
          default: c = CL_ALU;
        endcase
      end
      OP_BR:   if (f3 inside {3'd0, 3'd1, 3'd4, 3'd5}) c = CL_ALU;
      OP_LD:   if (f3 <= 3'd2) c = CL_LOAD;
      OP_ST:   if (f3 <= 3'd2) c = CL_STORE;
      OP_JAL:  c = CL_ALU;
      OP_LUI:  c = CL_ALU;
      OP_SYS:  c = CL_SYS;
      default: c = CL_ILLEGAL;
    endcase
    return c;
  endfunction

  // Build the queue entry
  always_comb begin
    dec_item.cls          = in_ch.kind ? CL_HOST : classify(in_ch.instr_word);
    dec_item.instr        = in_ch.instr_word;
    dec_item.host_address = in_ch.host_address;
    dec_item.host_word    = in_ch.host_word;
  end

  assign in_ch.ready = (q_cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (q_cnt_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = ent_r[rp_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= dec_item;
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd2) |-> !in_ch.ready)
    else $error("queue full but input ready");

endmodule

### rtl/core/rv32x_div.sv
// ----------------------------------------------------------------------------
// rv32x_div
// Iterative signed divide and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rv32x_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rv32x_pkg::div_req_t  req,
  output rv32x_pkg::div_rsp_t  rsp
);
  import rv32x_pkg::*;

  logic        run_r;
  logic        fin_r;
  logic [4:0]  cnt_r;
  logic [31:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] mb_r;
  logic        neg_q_r;
  logic        neg_a_r;
  logic        zero_r;
  logic        is_rem_r;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, mb_r};

  // Sequence the restoring divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      if (req.start) begin
        fin_r <= 1'b0;
        run_r <= 1'b1;
        cnt_r <= 5'd31;
        rem_r <= '0;
        quo_r <= req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
        mb_r  <= req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
        neg_q_r  <= req.dividend[31] ^ req.divisor[31];
        neg_a_r  <= req.dividend[31];
        zero_r   <= (req.divisor == 32'd0);
        is_rem_r <= req.is_rem;
      end else if (run_r) begin
        if (!diff[32]) begin
          rem_r <= diff[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= shifted[31:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        fin_r <= (cnt_r == 5'd0);
        if (cnt_r == 5'd0) begin
          run_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end else begin
        fin_r <= 1'b0;
      end
    end
  end

  // Apply signs and the divide-by-zero rule
  always_comb begin
    rsp.done = fin_r;
    if (is_rem_r)    rsp.value = neg_a_r ? 32'd0 - rem_r : rem_r;
    else if (zero_r) rsp.value = ALL_ONES;
    else             rsp.value = neg_q_r ? 32'd0 - quo_r : quo_r;
  end

endmodule

### rtl/core/rv32x_back.sv
// ----------------------------------------------------------------------------
// rv32x_back
// Executes queued requests against register file, PC and data memory.
// ----------------------------------------------------------------------------
module rv32x_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rv32x_pkg::item_t  q_item,
  input  logic              q_valid,
  output logic              q_ready,
  rv32x_out_if.source       out_ch,
  rv32x_cfg_if.sink         cfg_ch
);
  import rv32x_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DIVW, S_MWR, S_MRA, S_MRB, S_WB
  } state_t;

  state_t      st_r;
  item_t       cur_r;
  logic [31:0] pc_r;
  logic        halt_r;
  result_t     res_r;
  logic        res_halt_r;
  logic        out_valid_r;
  result_t     out_data_r;
  result_t     wb_res;
  logic [1:0]  cnt_r;
  logic [1:0]  sz_r;
  logic [MEM_AW-1:0] maddr_r;
  logic [31:0] wbuf_r;
  logic [31:0] ldbuf_r;
  logic signed [65:0] prod_r;

  // Register file with per-entry valid bits
  logic [31:0] rf [32];
  logic [31:0] rf_vld_r;
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;
  logic        rd_a_vld_r;
  logic        rd_b_vld_r;
  logic [4:0]  rf_ra;
  logic [4:0]  rf_rb;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] a;
  logic [31:0] b;

  // Data memory
  logic [7:0]        mem [MEM_BYTES];
  logic [7:0]        mem_rdata_r;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Execute-step results
  result_t     ex;
  logic        ex_halt;
  state_t      ex_state;
  logic [1:0]  ex_sz;
  logic [31:0] ex_addr;

  logic        out_free;
  logic [31:0] ld_nxt;
  logic [31:0] ld_ext;

  logic [31:0] w;
  logic [4:0]  d;
  logic [2:0]  f3;
  logic [31:0] immi;
  logic [31:0] imms;
  logic [31:0] off_j;
  logic [31:0] off_b;
  logic [31:0] opb;
  logic [4:0]  shamt;
  logic        cond;

  function automatic logic rng_ok(logic [31:0] addr, logic [1:0] last);
    return ({1'b0, addr} + 33'(last) + 33'd1) <= 33'(MEM_BYTES);
  endfunction

  assign q_ready  = (st_r == S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign a = rd_a_vld_r ? rd_a_r : 32'd0;
  assign b = rd_b_vld_r ? rd_b_r : 32'd0;

  // Read ports are issued when the request leaves the queue
  assign rf_ra = (q_item.cls == CL_SYS) ? 5'd10 : q_item.instr[19:15];
  assign rf_rb = (q_item.cls == CL_SYS) ? 5'd11 : q_item.instr[24:20];
  assign rf_we    = (st_r == S_WB) && out_free && (res_r.dest_index != 5'd0);
  assign rf_waddr = res_r.dest_index;

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_waddr] <= res_r.dest_value;
    rd_a_r <= rf[rf_ra];
    rd_b_r <= rf[rf_rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r   <= '0;
      rd_a_vld_r <= 1'b0;
      rd_b_vld_r <= 1'b0;
    end else begin
      if (rf_we) rf_vld_r[rf_waddr] <= 1'b1;
      rd_a_vld_r <= rf_vld_r[rf_ra];
      rd_b_vld_r <= rf_vld_r[rf_rb];
    end
  end

  // Byte-wide memory port
  assign mem_we    = (st_r == S_MWR);
  assign mem_addr  = maddr_r + MEM_AW'(cnt_r);
  assign mem_wdata = 8'(wbuf_r >> {cnt_r, 3'b000});

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_r <= mem[mem_addr];
  end

  // Assemble loaded bytes and sign-extend
  assign ld_nxt = ldbuf_r | (32'(mem_rdata_r) << {cnt_r, 3'b000});
  always_comb begin
    case (sz_r)
      2'd0:    ld_ext = {{24{ld_nxt[7]}}, ld_nxt[7:0]};
      2'd1:    ld_ext = {{16{ld_nxt[15]}}, ld_nxt[15:0]};
      default: ld_ext = ld_nxt;
    endcase
  end

  // Divider
  always_comb begin
    div_req.start    = (st_r == S_EXEC) && (ex_state == S_DIVW);
    div_req.is_rem   = cur_r.instr[13];
    div_req.dividend = a;
    div_req.divisor  = b;
  end

  rv32x_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Instruction fields
  assign w     = cur_r.instr;
  assign d     = w[11:7];
  assign f3    = w[14:12];
  assign immi  = {{20{w[31]}}, w[31:20]};
  assign imms  = {{20{w[31]}}, w[31:25], w[11:7]};
  assign off_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign off_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign opb   = (w[6:0] == OP_R) ? b : immi;
  assign shamt = (w[6:0] == OP_R) ? b[4:0] : w[24:20];

  // Execute step: result, next state and memory access setup
  always_comb begin
    ex = '{status: ST_OK, next_pc: pc_r + 32'd4, dest_index: 5'd0, dest_value: 32'd0,
           ecall_number: 32'd0, ecall_argument: 32'd0};
    ex_halt  = 1'b0;
    ex_state = S_WB;
    cond     = 1'b0;
    ex_sz    = (f3 == 3'd0) ? 2'd0 : ((f3 == 3'd1) ? 2'd1 : 2'd3);
    ex_addr  = a + immi;
    if (cur_r.cls == CL_HOST) begin
      ex.next_pc = pc_r;
      ex_sz      = 2'd3;
      ex_addr    = {16'd0, cur_r.host_address};
      if (rng_ok(ex_addr, 2'd3)) ex_state = S_MWR;
      else                       ex.status = ST_BADWRITE;
    end else if (halt_r) begin
      ex.status  = ST_HALTED;
      ex.next_pc = pc_r;
    end else begin
      case (cur_r.cls)
        CL_ALU: begin
          ex.dest_index = d;
          case (w[6:0])
            OP_LUI: ex.dest_value = {w[31:12], 12'd0};
            OP_JAL: begin
              ex.dest_value = pc_r + 32'd4;
              ex.next_pc    = pc_r + off_j;
            end
            OP_BR: begin
              ex.dest_index = 5'd0;
              case (f3)
                3'd0:    cond = (a == b);
                3'd1:    cond = (a != b);
                3'd4:    cond = ($signed(a) < $signed(b));
                default: cond = !($signed(a) < $signed(b));
              endcase
              if (cond) ex.next_pc = pc_r + off_b;
            end
            default: begin
              case (f3)
                3'd0: ex.dest_value = (w[6:0] == OP_R && w[30]) ? a - b : a + opb;
                3'd1: ex.dest_value = a << shamt;
                3'd2: ex.dest_value = {31'd0, $signed(a) < $signed(opb)};
                3'd4: ex.dest_value = a ^ opb;
                3'd5: ex.dest_value = w[30] ? 32'($signed(a) >>> shamt) : a >> shamt;
                3'd6: ex.dest_value = a | opb;
                default: ex.dest_value = a & opb;
              endcase
            end
          endcase
        end
        CL_MUL: begin
          ex.dest_index = d;
          ex_state      = S_MUL;
        end
        CL_DIV: begin
          ex.dest_index = d;
          ex_state      = S_DIVW;
        end
        CL_LOAD: begin
          if (rng_ok(ex_addr, ex_sz)) begin
            ex.dest_index = d;
            ex_state      = S_MRA;
          end else begin
            ex.status = ST_BADREAD;
          end
        end
        CL_STORE: begin
          ex_addr = a + imms;
          if (rng_ok(ex_addr, ex_sz)) ex_state = S_MWR;
          else                        ex.status = ST_BADWRITE;
        end
        CL_SYS: begin
          if (a == 32'd10) begin
            ex.status = ST_EXIT;
          end else if (a inside {32'd1, 32'd4, 32'd11}) begin
            ex.status         = ST_ECALL;
            ex.ecall_number   = a;
            ex.ecall_argument = b;
          end else begin
            ex.status = ST_ILLEGAL;
          end
        end
        default: ex.status = ST_ILLEGAL;
      endcase
      // Faults and exit hold the PC and set the halt
      if (ex.status != ST_OK && ex.status != ST_ECALL) begin
        ex.next_pc    = pc_r;
        ex.dest_index = 5'd0;
        ex_halt       = 1'b1;
        ex_state      = S_WB;
      end
    end
  end

  // Zero the value of a result that writes no register
  always_comb begin
    wb_res = res_r;
    if (res_r.dest_index == 5'd0) wb_res.dest_value = 32'd0;
  end

  // Multiplier, registered before selection
  always_ff @(posedge clk) begin
    if (st_r == S_EXEC) prod_r <= $signed({a[31], a}) * $signed({b[31], b});
  end

  // Back-end sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pc_r        <= 32'd0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (st_r == S_WB && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)        out_valid_r <= 1'b0;
      if (cfg_ch.valid && !(st_r == S_WB && out_free)) pc_r <= cfg_ch.start_pc;
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_item;
            st_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_r      <= ex;
          res_halt_r <= ex_halt;
          st_r       <= ex_state;
          cnt_r      <= 2'd0;
          sz_r       <= ex_sz;
          maddr_r    <= ex_addr[MEM_AW-1:0];
          wbuf_r     <= (cur_r.cls == CL_HOST) ? cur_r.host_word : b;
          ldbuf_r    <= 32'd0;
        end
        S_MUL: begin
          res_r.dest_value <= (f3 == 3'd0) ? prod_r[31:0] : prod_r[63:32];
          st_r <= S_WB;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            res_r.dest_value <= div_rsp.value;
            st_r <= S_WB;
          end
        end
        S_MWR: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == sz_r) st_r <= S_WB;
        end
        S_MRA: st_r <= S_MRB;
        S_MRB: begin
          ldbuf_r <= ld_nxt;
          if (cnt_r == sz_r) begin
            res_r.dest_value <= ld_ext;
            st_r <= S_WB;
          end else begin
            cnt_r <= cnt_r + 2'd1;
            st_r  <= S_MRA;
          end
        end
        S_WB: begin
          // Commit and hand the result to the output register
          if (out_free) begin
            out_data_r <= wb_res;
            pc_r <= res_r.next_pc;
            if (res_halt_r) halt_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_data_r.status;
  assign out_ch.next_pc        = out_data_r.next_pc;
  assign out_ch.dest_index     = out_data_r.dest_index;
  assign out_ch.dest_value     = out_data_r.dest_value;
  assign out_ch.ecall_number   = out_data_r.ecall_number;
  assign out_ch.ecall_argument = out_data_r.ecall_argument;

  a_halted_report: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EXEC && halt_r && cur_r.cls != CL_HOST)
      |=> (st_r == S_WB && res_r.status == ST_HALTED))
    else $error("halted instruction not reported as halted");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (rf_waddr != 5'd0))
    else $error("write to x0");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt cleared without reset");

  a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIVW && div_rsp.done) |=> (st_r == S_WB))
    else $error("divide result not taken");

endmodule
